>>> rtl/core/sfc_pkg.sv
// sfc_pkg: shared constants for the signature file carver
// holds marker bytes, field widths, register indexes and parameter defaults
// no dependencies
package sfc_pkg;

  // end-of-image marker bytes
  localparam logic [7:0] MARKER_FIRST  = 8'hff;
  localparam logic [7:0] MARKER_SECOND = 8'hd9;

  // signature storage and position counters
  localparam int SIG_BYTES_MAX = 12;
  localparam int SIG_POS_W     = 4;
  localparam int MODE_W        = 3;

  // file counter
  localparam int                  COUNT_W   = 24;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

  // configuration port
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 1;
  localparam int SIG_LAST_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_SIG_FIRST = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIG_LAST  = 1'b1;

  // parameter defaults
  localparam int DEF_SIGNATURE_BYTES  = 12;
  localparam int DEF_MARKERS_PER_FILE = 4;

endpackage

>>> rtl/core/signature_file_carver.sv
// signature_file_carver: scans a byte stream for a configured signature and
// passes the carved file bytes downstream until the final end marker
// depends on sfc_pkg
//
// channel  | direction | contents
// ---------+-----------+---------------------------------------------------
// s_axis   | in        | tdata[7:0] in_byte
// m_axis   | out       | tdata[7:0] out_byte, [31:8] file_number;
//          |           | tuser[0] file_start, [1] file_end; tlast last
// cfg      | in        | cfg_we, cfg_index, cfg_data (no read-back)
//
// one input beat per cycle while searching or inside a file body, unless m_tready holds the output
// a completed signature sends SIGNATURE_BYTES output beats, one per cycle while m_tready is high;
// the input is held off for the rest of that burst
// the output register decouples the sides: input keeps flowing when the
// held result is taken in the same cycle
// rst is synchronous and clears all control state and the signature
module signature_file_carver #(
  parameter int SIGNATURE_BYTES  = sfc_pkg::DEF_SIGNATURE_BYTES,
  parameter int MARKERS_PER_FILE = sfc_pkg::DEF_MARKERS_PER_FILE
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] in_byte
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,   // [7:0] out_byte, [31:8] file_number
  output logic [1:0]                        m_tuser,   // [0] file_start, [1] file_end
  output logic                              m_tlast,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [sfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import sfc_pkg::*;

  localparam logic [SIG_POS_W-1:0] SIG_LEN   = SIG_POS_W'(SIGNATURE_BYTES);
  localparam logic [SIG_POS_W-1:0] SIG_FINAL = SIG_POS_W'(SIGNATURE_BYTES - 1);
  localparam logic [MODE_W-1:0]    MARK_CNT  = MODE_W'(MARKERS_PER_FILE);
  localparam logic [MODE_W-1:0]    MODE_SEARCH = '0;
  localparam logic [MODE_W-1:0]    MODE_BODY   = MODE_W'(1);

  // configuration registers
  logic [CFG_DATA_W-1:0] sig_first;
  logic [SIG_LAST_W-1:0] sig_last;

  // scan state
  logic [SIG_POS_W-1:0] sig_pos;
  logic                 marker_pos;
  logic [MODE_W-1:0]    mode;
  logic [COUNT_W-1:0]   file_count;

  // signature burst state
  logic                 burst_active;
  logic [SIG_POS_W-1:0] burst_idx;

  // output register
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_start;
  logic               out_end;
  logic [COUNT_W-1:0] out_number;
  logic               out_last;

  logic [7:0]         sig_arr [SIG_BYTES_MAX];
  logic               out_free;
  logic               in_accept;
  logic               sig_hit;
  logic [SIG_POS_W-1:0] pos_inc;
  logic               sig_done;
  logic [7:0]         marker_want;
  logic               marker_hit;
  logic               marker_done;
  logic               file_fin;

  // signature bytes as an indexed table
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      sig_arr[k] = sig_first[8*k +: 8];
    end
    for (int k = 8; k < SIG_BYTES_MAX; k++) begin
      sig_arr[k] = sig_last[8*(k-8) +: 8];
    end
  end

  // handshake
  assign out_free  = !out_valid || m_tready;
  assign s_tready  = !burst_active && out_free;
  assign in_accept = s_tvalid && s_tready;

  // search and marker compare
  assign sig_hit     = (sig_arr[sig_pos] == s_tdata);
  assign pos_inc     = sig_pos + SIG_POS_W'(1);
  assign sig_done    = sig_hit && (pos_inc == SIG_LEN);
  assign marker_want = marker_pos ? MARKER_SECOND : MARKER_FIRST;
  assign marker_hit  = (s_tdata == marker_want);
  assign marker_done = marker_hit && marker_pos;
  assign file_fin    = marker_done && (mode >= MARK_CNT);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_first <= '0;
      sig_last  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIG_FIRST: sig_first <= cfg_data;
        REG_SIG_LAST:  sig_last  <= cfg_data[SIG_LAST_W-1:0];
        default: ;
      endcase
    end
  end

  // scan state, burst sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_pos      <= '0;
      marker_pos   <= 1'b0;
      mode         <= MODE_SEARCH;
      file_count   <= '0;
      burst_active <= 1'b0;
      burst_idx    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (burst_active && out_free) begin
        // remaining signature beats
        out_valid  <= 1'b1;
        out_byte   <= sig_arr[burst_idx];
        out_start  <= 1'b0;
        out_end    <= 1'b0;
        out_number <= file_count;
        out_last   <= (burst_idx == SIG_FINAL);
        burst_idx  <= burst_idx + SIG_POS_W'(1);
        if (burst_idx == SIG_FINAL) begin
          burst_active <= 1'b0;
        end
      end else if (in_accept) begin
        if (mode == MODE_SEARCH) begin
          if (sig_done) begin
            // signature found: open a file, first signature beat now
            sig_pos      <= '0;
            marker_pos   <= 1'b0;
            mode         <= MODE_BODY;
            out_valid    <= 1'b1;
            out_byte     <= sig_arr[0];
            out_start    <= 1'b1;
            out_end      <= 1'b0;
            out_number   <= file_count;
            out_last     <= (SIGNATURE_BYTES == 1);
            burst_active <= (SIGNATURE_BYTES > 1);
            burst_idx    <= SIG_POS_W'(1);
          end else begin
            sig_pos <= sig_hit ? pos_inc : '0;
            if (m_tready) begin
              out_valid <= 1'b0;
            end
          end
        end else begin
          // file body: pass the byte through, track end markers
          out_valid  <= 1'b1;
          out_byte   <= s_tdata;
          out_start  <= 1'b0;
          out_end    <= file_fin;
          out_number <= file_count;
          out_last   <= 1'b1;
          marker_pos <= marker_hit && !marker_pos;
          if (file_fin) begin
            mode    <= MODE_SEARCH;
            sig_pos <= '0;
            if (file_count != COUNT_MAX) begin
              file_count <= file_count + COUNT_W'(1);
            end
          end else if (marker_done) begin
            mode <= mode + MODE_W'(1);
          end
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output ports
  assign m_tvalid = out_valid;
  assign m_tdata  = {out_number, out_byte};
  assign m_tuser  = {out_end, out_start};
  assign m_tlast  = out_last;

  // checks
  a_burst_blocks_input: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> !s_tready)
    else $error("input accepted during signature burst");

  a_burst_in_body: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> (mode == MODE_BODY))
    else $error("signature burst outside first body state");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    sig_pos < SIG_LEN)
    else $error("signature position out of range");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode <= MARK_CNT)
    else $error("marker count out of range");

  a_start_not_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
    else $error("file start and end on the same beat");

endmodule
